// ===== rtl/wpps_pkg.sv =====
// shared types and constants for the weighted profile perturbation statistics block
// no dependencies
package wpps_pkg;

  localparam int DIVD_W = 64;
  localparam int DIVS_W = 40;
  localparam int CNT_W  = 7;

  localparam logic REG_WEIGHTING   = 1'b0;
  localparam logic REG_TABLE_COUNT = 1'b1;

  localparam logic REQ_TABLE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] DIV_INTERP = 2'd0;
  localparam logic [1:0] DIV_MIN    = 2'd1;
  localparam logic [1:0] DIV_MAX    = 2'd2;
  localparam logic [1:0] DIV_VAR    = 2'd3;

  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] SAT40 = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic       load;
    logic       rd_first;
    logic       rd_last;
    logic       rd_mid;
    logic       rd_lo;
    logic       rd_hi;
    logic       cap_first;
    logic       cap_last;
    logic       cap_mid;
    logic       cap_lo;
    logic       cap_hi;
    logic       mul_interp;
    logic       div_start;
    logic [1:0] div_sel;
    logic       w_from_div;
    logic       w_y0;
    logic       w_zero;
    logic       acc_mul;
    logic       acc_sq;
    logic       acc_upd;
    logic       fin_min;
    logic       fin_max;
    logic       fin_var;
    logic       fin_direct;
    logic       emit;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic in_is_sample;
    logic pv;
    logic last;
    logic need_w;
    logic weighted;
    logic out_of_range;
    logic search_done;
    logic den_zero;
    logic degenerate;
    logic div_busy;
    logic out_hold;
  } status_t;

endpackage

// ===== rtl/wpps_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
module wpps_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wpps_div.sv =====
// shared restoring divider, one quotient bit per cycle, with half-up round flag
// depends on wpps_pkg
module wpps_div
  import wpps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  bits,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quot,
  output logic              round_up
);

  logic [DIVD_W-1:0] acc;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W:0]   sh;
  logic              ge;

  assign sh       = {rem, acc[DIVD_W-1]};
  assign ge       = sh >= {1'b0, dvs};
  assign busy     = cnt != '0;
  assign quot     = acc;
  assign round_up = {rem, 1'b0} >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= bits;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= {acc[DIVD_W-2:0], ge};
      rem <= ge ? DIVS_W'(sh - {1'b0, dvs}) : sh[DIVS_W-1:0];
    end
  end

endmodule

// ===== rtl/wpps_datapath.sv =====
// datapath: config registers, table ram, search and interpolation, accumulators, output
// depends on wpps_pkg, wpps_ram, wpps_div
module wpps_datapath
  import wpps_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               req_type,
  input  logic [5:0]         table_index,
  input  logic [16:0]        table_altitude,
  input  logic [15:0]        table_weight,
  input  logic [16:0]        sample_altitude,
  input  logic signed [15:0] perturbation,
  input  logic               pert_finite,
  input  logic               temp_finite,
  input  logic               profile_valid,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] min_pert,
  output logic signed [23:0] max_pert,
  output logic [47:0]        variance,
  output logic               degenerate
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  logic              weighting_enable;
  logic [6:0]        table_count;
  logic [NW-1:0]     n_use;

  logic [16:0]        z;
  logic signed [15:0] pt;
  logic               pf, tf, pv, last;
  logic               need_w;

  logic              ram_we;
  logic [AW-1:0]     raddr;
  logic [32:0]       rdata;

  logic [AW-1:0]     lo, hi, mid;
  logic [16:0]       alt_first, alt_last;
  logic [16:0]       z0, z1;
  logic [15:0]       y0, y1;

  logic signed [16:0] dy;
  logic signed [17:0] den;
  logic [15:0]        dy_mag;
  logic [16:0]        den_mag;
  logic [16:0]        dz;
  logic [32:0]        num_mag;
  logic [16:0]        den_mag_r;
  logic               num_neg;

  logic [15:0]        w;
  logic signed [32:0] val;
  logic [31:0]        w2;
  logic [63:0]        sq;
  logic [31:0]        val_mag;

  logic signed [32:0] run_min, run_max;
  logic [63:0]        sqsum;
  logic [39:0]        wsum2;
  logic [15:0]        peak;

  logic               div_start;
  logic [DIVD_W-1:0]  div_dividend;
  logic [CNT_W-1:0]   div_bits;
  logic [DIVS_W-1:0]  div_divisor;
  logic               div_busy;
  logic [DIVD_W-1:0]  div_quot;
  logic               div_round;
  logic [64:0]        qr;

  logic signed [39:0] w_sum;
  logic [64:0]        sq_add;
  logic [40:0]        w2_add;
  logic [32:0]        min_mag;

  logic signed [23:0] res_min, res_max;
  logic [47:0]        res_var;
  logic               res_deg;

  function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
    if (v > 33'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -33'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      weighting_enable <= 1'b0;
      table_count      <= 7'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WEIGHTING:   weighting_enable <= cfg_data[0];
        REG_TABLE_COUNT: table_count      <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (table_count < 7'd2) begin
      n_use = NW'(2);
    end else if (32'(table_count) > TABLE_DEPTH) begin
      n_use = NW'(TABLE_DEPTH);
    end else begin
      n_use = NW'(table_count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z    <= sample_altitude;
      pt   <= perturbation;
      pf   <= pert_finite;
      tf   <= temp_finite;
      pv   <= profile_valid;
      last <= last_sample;
    end
  end

  assign need_w = weighting_enable & tf & (~pf | (pt != 16'sd0));

  assign ram_we = cmd.load & (req_type == REQ_TABLE) & (32'(table_index) < TABLE_DEPTH);

  assign mid = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  always_comb begin
    priority if (cmd.rd_last) begin
      raddr = AW'(n_use - NW'(1));
    end else if (cmd.rd_mid) begin
      raddr = mid;
    end else if (cmd.rd_lo) begin
      raddr = lo;
    end else if (cmd.rd_hi) begin
      raddr = AW'({1'b0, lo} + (AW + 1)'(1));
    end else if (cmd.rd_first) begin
      raddr = '0;
    end else begin
      raddr = '0;
    end
  end

  wpps_ram #(
    .WIDTH (33),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(table_index)),
    .wdata ({table_altitude, table_weight}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo <= '0;
      hi <= AW'(n_use - NW'(1));
    end else if (cmd.cap_mid) begin
      if (z > rdata[32:16]) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.cap_first) alt_first <= rdata[32:16];
    if (cmd.cap_last) alt_last <= rdata[32:16];
    if (cmd.cap_lo) begin
      z0 <= rdata[32:16];
      y0 <= rdata[15:0];
    end
    if (cmd.cap_hi) begin
      z1 <= rdata[32:16];
      y1 <= rdata[15:0];
    end
  end

  // interpolation terms
  assign dy      = $signed({1'b0, y1}) - $signed({1'b0, y0});
  assign den     = $signed({1'b0, z1}) - $signed({1'b0, z0});
  assign dy_mag  = dy[16] ? 16'(-dy) : dy[15:0];
  assign den_mag = den[17] ? 17'(-den) : den[16:0];
  assign dz      = z - z0;

  always_ff @(posedge clk) begin
    if (cmd.mul_interp) begin
      num_mag   <= 33'(dy_mag) * 33'(dz);
      den_mag_r <= den_mag;
      num_neg   <= dy[16] ^ den[17];
    end
  end

  assign min_mag = 33'(-run_min);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_INTERP: begin
        div_dividend = {num_mag, 31'b0};
        div_bits     = CNT_W'(33);
        div_divisor  = DIVS_W'(den_mag_r);
      end
      DIV_MIN: begin
        div_dividend = {min_mag, 31'b0};
        div_bits     = CNT_W'(33);
        div_divisor  = DIVS_W'(peak);
      end
      DIV_MAX: begin
        div_dividend = {33'(run_max), 31'b0};
        div_bits     = CNT_W'(33);
        div_divisor  = DIVS_W'(peak);
      end
      DIV_VAR: begin
        div_dividend = sqsum;
        div_bits     = CNT_W'(64);
        div_divisor  = wsum2;
      end
    endcase
  end

  assign div_start = cmd.div_start;

  wpps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .bits     (div_bits),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .round_up (div_round)
  );

  assign qr = 65'(div_quot) + 65'(div_round);

  assign w_sum = num_neg ? $signed({24'b0, y0}) - $signed({1'b0, qr[38:0]})
                         : $signed({24'b0, y0}) + $signed({1'b0, qr[38:0]});

  always_ff @(posedge clk) begin
    if (cmd.w_zero) begin
      w <= '0;
    end else if (cmd.w_y0) begin
      w <= y0;
    end else if (cmd.w_from_div) begin
      if (w_sum < 40'sd0) begin
        w <= '0;
      end else if (w_sum > 40'sd65535) begin
        w <= 16'hFFFF;
      end else begin
        w <= w_sum[15:0];
      end
    end
  end

  // sample value and squares
  assign val_mag = val[32] ? 32'(-val) : val[31:0];

  always_ff @(posedge clk) begin
    if (cmd.acc_mul) begin
      if (need_w) begin
        val <= 33'(pt) * $signed({17'b0, w});
      end else if (weighting_enable) begin
        val <= 33'(pt) <<< 16;
      end else begin
        val <= 33'(pt);
      end
      w2 <= 32'(w) * 32'(w);
    end
    if (cmd.acc_sq) begin
      sq <= 64'(val_mag) * 64'(val_mag);
    end
  end

  assign sq_add = {1'b0, sqsum} + {1'b0, sq};
  assign w2_add = {1'b0, wsum2} + 41'(w2);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      run_min <= '0;
      run_max <= '0;
      sqsum   <= '0;
      wsum2   <= '0;
      peak    <= '0;
    end else if (cmd.acc_upd) begin
      if (pf) begin
        if (val < run_min) run_min <= val;
        if (val > run_max) run_max <= val;
        sqsum <= sq_add[64] ? '1 : sq_add[63:0];
      end
      if (need_w) begin
        if (w > peak) peak <= w;
        wsum2 <= (w2_add > {1'b0, SAT40}) ? SAT40 : w2_add[39:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_direct) begin
      if (weighting_enable) begin
        res_min <= '0;
        res_max <= '0;
        res_var <= '0;
        res_deg <= 1'b1;
      end else begin
        res_min <= sat24(run_min);
        res_max <= sat24(run_max);
        res_var <= (sqsum > 64'(SAT48)) ? SAT48 : sqsum[47:0];
        res_deg <= 1'b0;
      end
    end
    if (cmd.fin_min) begin
      res_min <= (qr > 65'd8388608) ? 24'sh800000 : 24'(24'd0 - qr[23:0]);
      res_deg <= 1'b0;
    end
    if (cmd.fin_max) begin
      res_max <= (qr > 65'd8388607) ? 24'sh7FFFFF : qr[23:0];
    end
    if (cmd.fin_var) begin
      res_var <= (qr > 65'(SAT48)) ? SAT48 : qr[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      min_pert   <= res_min;
      max_pert   <= res_max;
      variance   <= res_var;
      degenerate <= res_deg;
    end
  end

  assign status.in_is_sample = req_type == REQ_SAMPLE;
  assign status.pv           = pv;
  assign status.last         = last;
  assign status.need_w       = need_w;
  assign status.weighted     = weighting_enable;
  assign status.out_of_range = (z < alt_first) | (z > alt_last);
  assign status.search_done  = {1'b0, hi} <= ({1'b0, lo} + (AW + 1)'(1));
  assign status.den_zero     = z1 == z0;
  assign status.degenerate   = (peak == '0) | (wsum2 == '0);
  assign status.div_busy     = div_busy;
  assign status.out_hold     = out_valid & out_stall;

endmodule

// ===== rtl/wpps_ctrl.sv =====
// controller state machine sequencing search, interpolation, accumulation and final divisions
// depends on wpps_pkg
module wpps_ctrl
  import wpps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECIDE   = 5'd1;
  localparam logic [4:0] S_RD_FIRST = 5'd2;
  localparam logic [4:0] S_RD_LAST  = 5'd3;
  localparam logic [4:0] S_CHK_LAST = 5'd4;
  localparam logic [4:0] S_RANGE    = 5'd5;
  localparam logic [4:0] S_SEARCH   = 5'd6;
  localparam logic [4:0] S_SRCH_CMP = 5'd7;
  localparam logic [4:0] S_RD_LO    = 5'd8;
  localparam logic [4:0] S_RD_HI    = 5'd9;
  localparam logic [4:0] S_CAP_HI   = 5'd10;
  localparam logic [4:0] S_INTERP   = 5'd11;
  localparam logic [4:0] S_I_GO     = 5'd12;
  localparam logic [4:0] S_I_WAIT   = 5'd13;
  localparam logic [4:0] S_ACC_MUL  = 5'd14;
  localparam logic [4:0] S_ACC_SQ   = 5'd15;
  localparam logic [4:0] S_ACC_UPD  = 5'd16;
  localparam logic [4:0] S_END      = 5'd17;
  localparam logic [4:0] S_MN_GO    = 5'd18;
  localparam logic [4:0] S_MN_WAIT  = 5'd19;
  localparam logic [4:0] S_MX_GO    = 5'd20;
  localparam logic [4:0] S_MX_WAIT  = 5'd21;
  localparam logic [4:0] S_V_GO     = 5'd22;
  localparam logic [4:0] S_V_WAIT   = 5'd23;
  localparam logic [4:0] S_EMIT     = 5'd24;

  logic [4:0] state, state_next;

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_is_sample) state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status.pv) begin
          state_next = S_END;
        end else if (status.need_w) begin
          state_next = S_RD_FIRST;
        end else begin
          state_next = S_ACC_MUL;
        end
      end
      S_RD_FIRST: begin
        cmd.rd_first = 1'b1;
        state_next   = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.rd_last   = 1'b1;
        cmd.cap_first = 1'b1;
        state_next    = S_CHK_LAST;
      end
      S_CHK_LAST: begin
        cmd.cap_last = 1'b1;
        state_next   = S_RANGE;
      end
      S_RANGE: begin
        if (status.out_of_range) begin
          cmd.w_zero = 1'b1;
          state_next = S_ACC_MUL;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.search_done) begin
          cmd.rd_lo  = 1'b1;
          state_next = S_RD_HI;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.cap_mid = 1'b1;
        state_next  = S_SEARCH;
      end
      S_RD_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_hi  = 1'b1;
        cmd.cap_lo = 1'b1;
        state_next = S_CAP_HI;
      end
      S_CAP_HI: begin
        cmd.cap_hi = 1'b1;
        state_next = S_INTERP;
      end
      S_INTERP: begin
        if (status.den_zero) begin
          cmd.w_y0   = 1'b1;
          state_next = S_ACC_MUL;
        end else begin
          cmd.mul_interp = 1'b1;
          state_next     = S_I_GO;
        end
      end
      S_I_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_INTERP;
        state_next    = S_I_WAIT;
      end
      S_I_WAIT: begin
        if (!status.div_busy) begin
          cmd.w_from_div = 1'b1;
          state_next     = S_ACC_MUL;
        end
      end
      S_ACC_MUL: begin
        cmd.acc_mul = 1'b1;
        state_next  = S_ACC_SQ;
      end
      S_ACC_SQ: begin
        cmd.acc_sq = 1'b1;
        state_next = S_ACC_UPD;
      end
      S_ACC_UPD: begin
        cmd.acc_upd = 1'b1;
        state_next  = S_END;
      end
      S_END: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (!status.pv) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (status.weighted && !status.degenerate) begin
          state_next = S_MN_GO;
        end else begin
          cmd.fin_direct = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_MN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MIN;
        state_next    = S_MN_WAIT;
      end
      S_MN_WAIT: begin
        if (!status.div_busy) begin
          cmd.fin_min = 1'b1;
          state_next  = S_MX_GO;
        end
      end
      S_MX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MAX;
        state_next    = S_MX_WAIT;
      end
      S_MX_WAIT: begin
        if (!status.div_busy) begin
          cmd.fin_max = 1'b1;
          state_next  = S_V_GO;
        end
      end
      S_V_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VAR;
        state_next    = S_V_WAIT;
      end
      S_V_WAIT: begin
        if (!status.div_busy) begin
          cmd.fin_var = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.out_hold) begin
          cmd.emit   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/weighted_profile_perturbation_stats.sv =====
// top level of the weighted profile perturbation statistics block
// depends on wpps_pkg, wpps_ctrl, wpps_datapath
//
//  port group   direction  handshake             payload
//  in           in         in_valid / in_stall   req_type .. last_sample
//  out          out        out_valid / out_stall min_pert, max_pert, variance, degenerate
//  cfg          in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// a table write is stored in the idle state; an unweighted or unscaled sample goes through
// multiply, square and update; a weighted sample outside the table gets weight zero, inside it
// a binary search and, if the altitudes differ, a division in the shared one-bit-a-cycle divider
// set the weight; a last sample of a valid profile emits, if weighted after three divisions
// synchronous active-high reset clears control state and the accumulators
// the next item is taken while a result waits on out_stall; a new result waits for it
module weighted_profile_perturbation_stats
  import wpps_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [5:0]         table_index,
  input  logic [16:0]        table_altitude,
  input  logic [15:0]        table_weight,
  input  logic [16:0]        sample_altitude,
  input  logic signed [15:0] perturbation,
  input  logic               pert_finite,
  input  logic               temp_finite,
  input  logic               profile_valid,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] min_pert,
  output logic signed [23:0] max_pert,
  output logic [47:0]        variance,
  output logic               degenerate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  wpps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  wpps_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .table_index     (table_index),
    .table_altitude  (table_altitude),
    .table_weight    (table_weight),
    .sample_altitude (sample_altitude),
    .perturbation    (perturbation),
    .pert_finite     (pert_finite),
    .temp_finite     (temp_finite),
    .profile_valid   (profile_valid),
    .last_sample     (last_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .min_pert        (min_pert),
    .max_pert        (max_pert),
    .variance        (variance),
    .degenerate      (degenerate)
  );

endmodule
